// File: rtl/fbc_pkg.sv
// shared constants for the frustum box cull block
package fbc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 4 * COEF_W;
  localparam int IDX_W       = 3;
  localparam int SEL_W       = 3;
  localparam int CLASS_W     = 2;
  localparam int COORD_W_DEF = 16;
  localparam int FRAC_DEF    = 8;

  localparam logic [SEL_W-1:0] SEL_ALL = 3'd6;

  localparam logic CMD_CLASSIFY = 1'b0;
  localparam logic CMD_CORNER   = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_OUTSIDE = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_CROSS   = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_INSIDE  = 2'd2;

  localparam int LATENCY = 5;

endpackage

// File: rtl/frustum_box_cull_top.sv
// frustum box cull: five-stage pipeline testing a box against six planes
// start passes stages 1 to 4; the stage 5 register then raises done with the word
// throughput: one box per cycle, busy is never raised, the receiver cannot stall
// the 36 coefficient by coordinate products in stage two set the depth
// reset (rst, synchronous) clears the plane registers and all stage valid bits
module frustum_box_cull_top #(
  parameter int COORD_WIDTH = fbc_pkg::COORD_W_DEF,
  parameter int FRAC_BITS   = fbc_pkg::FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          command,
  input  logic [fbc_pkg::SEL_W-1:0]     plane_select,
  input  logic signed [COORD_WIDTH-1:0] box_min_x,
  input  logic signed [COORD_WIDTH-1:0] box_min_y,
  input  logic signed [COORD_WIDTH-1:0] box_min_z,
  input  logic signed [COORD_WIDTH-1:0] box_max_x,
  input  logic signed [COORD_WIDTH-1:0] box_max_y,
  input  logic signed [COORD_WIDTH-1:0] box_max_z,
  input  logic                          cfg_we,
  input  logic [fbc_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fbc_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output logic                          visible,
  output logic [fbc_pkg::CLASS_W-1:0]   box_class
);

  localparam int NP = fbc_pkg::NUM_PLANES;
  localparam int CW = fbc_pkg::COEF_W;
  localparam int PW = CW + COORD_WIDTH;
  localparam int DW = CW + FRAC_BITS;
  localparam int SW = ((PW > DW) ? PW : DW) + 2;

  logic [fbc_pkg::CFG_W-1:0] plane [NP];

  logic signed [CW-1:0] coef [NP][4];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < 4; k++) begin
        coef[p][k] = plane[p][k*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NP; p++) plane[p] <= '0;
    end else if (cfg_we && (int'(cfg_index) < NP)) begin
      plane[cfg_index] <= cfg_data;
    end
  end

  assign busy = 1'b0;

  // stage 1: input capture
  logic                          v1, cmd1;
  logic [fbc_pkg::SEL_W-1:0]     sel1;
  logic signed [COORD_WIDTH-1:0] lo1 [3];
  logic signed [COORD_WIDTH-1:0] hi1 [3];

  // stage 2: products for min and max of every axis and plane
  logic                      v2, cmd2;
  logic [fbc_pkg::SEL_W-1:0] sel2;
  logic signed [PW-1:0]      prod_lo [NP][3];
  logic signed [PW-1:0]      prod_hi [NP][3];

  // stage 3: x+y pairs and z+d pairs
  logic                      v3, cmd3;
  logic [fbc_pkg::SEL_W-1:0] sel3;
  logic signed [SW-1:0]      pxy [NP][4];
  logic signed [SW-1:0]      pzd [NP][2];

  // stage 4: behind flag per plane and corner
  logic                      v4, cmd4;
  logic [fbc_pkg::SEL_W-1:0] sel4;
  logic [7:0]                beh [NP];
  logic signed [SW-1:0]      corner_sum [NP][8];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int c = 0; c < 8; c++) begin
        corner_sum[p][c] = pxy[p][c % 4] + pzd[p][c / 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    cmd1 <= command;
    sel1 <= plane_select;
    lo1[0] <= box_min_x;
    lo1[1] <= box_min_y;
    lo1[2] <= box_min_z;
    hi1[0] <= box_max_x;
    hi1[1] <= box_max_y;
    hi1[2] <= box_max_z;

    cmd2 <= cmd1;
    sel2 <= sel1;
    for (int p = 0; p < NP; p++) begin
      for (int a = 0; a < 3; a++) begin
        prod_lo[p][a] <= PW'(coef[p][a]) * PW'(lo1[a]);
        prod_hi[p][a] <= PW'(coef[p][a]) * PW'(hi1[a]);
      end
    end

    cmd3 <= cmd2;
    sel3 <= sel2;
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < 4; k++) begin
        pxy[p][k] <= SW'(k[0] ? prod_hi[p][0] : prod_lo[p][0])
                   + SW'(k[1] ? prod_hi[p][1] : prod_lo[p][1]);
      end
      pzd[p][0] <= SW'(prod_lo[p][2]) + (SW'(coef[p][3]) <<< FRAC_BITS);
      pzd[p][1] <= SW'(prod_hi[p][2]) + (SW'(coef[p][3]) <<< FRAC_BITS);
    end

    cmd4 <= cmd3;
    sel4 <= sel3;
    for (int p = 0; p < NP; p++) begin
      for (int c = 0; c < 8; c++) begin
        beh[p][c] <= corner_sum[p][c][SW-1];
      end
    end
  end

  // stage 5: reduce to the result word
  logic                        vis_next;
  logic [fbc_pkg::CLASS_W-1:0] class_next;
  logic                        outside, crossing;
  logic [2:0]                  pos_idx;
  logic [7:0]                  corner_ok;

  always_comb begin
    outside  = 1'b0;
    crossing = 1'b0;
    for (int p = 0; p < NP; p++) begin
      // positive corner takes max where the normal component is non-negative
      pos_idx = {~coef[p][2][CW-1], ~coef[p][1][CW-1], ~coef[p][0][CW-1]};
      outside  = outside  | beh[p][pos_idx];
      crossing = crossing | beh[p][~pos_idx];
    end
    for (int c = 0; c < 8; c++) begin
      corner_ok[c] = 1'b1;
      if (sel4 >= fbc_pkg::SEL_ALL) begin
        for (int p = 0; p < NP; p++) corner_ok[c] = corner_ok[c] & ~beh[p][c];
      end else begin
        corner_ok[c] = ~beh[sel4][c];
      end
    end
    if (cmd4 == fbc_pkg::CMD_CORNER) begin
      vis_next   = |corner_ok;
      class_next = fbc_pkg::CLASS_OUTSIDE;
    end else if (outside) begin
      vis_next   = 1'b0;
      class_next = fbc_pkg::CLASS_OUTSIDE;
    end else if (crossing) begin
      vis_next   = 1'b1;
      class_next = fbc_pkg::CLASS_CROSS;
    end else begin
      vis_next   = 1'b1;
      class_next = fbc_pkg::CLASS_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
    visible   <= vis_next;
    box_class <= class_next;
  end

endmodule

// File: rtl/fbc_checker.sv
// port-level checker for the frustum box cull block, with its bind
module fbc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic                        visible,
  input logic [fbc_pkg::CLASS_W-1:0] box_class
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##5 done)
    else $error("word missing five cycles after start");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, fbc_pkg::LATENCY))
    else $error("word without a start");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (box_class == fbc_pkg::CLASS_OUTSIDE || box_class == fbc_pkg::CLASS_CROSS
              || box_class == fbc_pkg::CLASS_INSIDE))
    else $error("bad class code");

  a_hidden_outside: assert property (@(posedge clk) disable iff (rst)
    (done && !visible) |-> box_class == fbc_pkg::CLASS_OUTSIDE)
    else $error("culled box with a non-outside class");

endmodule

bind frustum_box_cull_top fbc_checker u_fbc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .visible(visible), .box_class(box_class)
);
